@@ sv/actr_pkg.sv @@
// package for the aes counter-mode random byte generator
// holds widths, the aes s-box, round constants and round helper functions
package actr_pkg;

    localparam int MAX_REQUEST_BYTES = 1024;
    localparam int COUNT_W = 11;
    localparam int VB_W = 5;
    localparam int BLK_W = COUNT_W - 4;
    localparam int FIFO_DEPTH = 2;

    // one queue entry: block count and valid bytes of the last block
    typedef struct packed {
        logic [BLK_W-1:0] blocks;
        logic [VB_W-1:0]  last_bytes;
    } t_job;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h01;
            4'd1: r = 8'h02;
            4'd2: r = 8'h04;
            4'd3: r = 8'h08;
            4'd4: r = 8'h10;
            4'd5: r = 8'h20;
            4'd6: r = 8'h40;
            4'd7: r = 8'h80;
            4'd8: r = 8'h1b;
            4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // state byte i sits in bits 8i+7:8i
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
        logic [7:0] t [16];
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (final_rnd) begin
                o[32*c +: 32] = {a3, a2, a1, a0};
            end else begin
                o[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
                o[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
                o[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                o[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        return o;
    endfunction

    // key word w (byte 4c in top bits) to state byte order
    function automatic logic [127:0] key_to_state(input logic [127:0] k);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[8*(4*c+r) +: 8] = k[32*(3-c) + 24 - 8*r +: 8];
            end
        end
        return o;
    endfunction

    // next round key, words packed {w0,w1,w2,w3}
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] i);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
            ^ {rcon(i), 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

@@ sv/aes_ctr_random_bytes.sv @@
// top level of the aes-128 counter-mode random byte generator
// depends on actr_pkg, actr_front, actr_back
// Each request of N bytes (capped at 1024) yields max(1, ceil(N/16)) blocks of
// 16 cipher bytes; the last block carries the count of valid bytes. A block
// is issued (counter bumped, whitened with round key 0) and then runs in the
// round unit (one aes round per cycle, round keys made on the fly); a new
// request is picked up from the idle state before its first issue. A stalled
// output holds the final round until the output register frees. Requests
// queue in a two-entry buffer ahead of the round unit. Writing the seed
// reloads the key and clears the counter; write it only while idle.
module aes_ctr_random_bytes import actr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [10:0]  i_byte_count,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_block_low,
    output logic [63:0]  o_block_high,
    output logic [4:0]   o_valid_bytes,
    output logic         o_last_block
);
    logic job_valid, job_take;
    t_job job;

    actr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_byte_count,
        .o_job_valid(job_valid), .o_job(job), .i_job_take(job_take)
    );

    actr_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_job_valid(job_valid), .i_job(job), .o_job_take(job_take),
        .o_valid, .i_stall, .o_block_low, .o_block_high,
        .o_valid_bytes, .o_last_block
    );
endmodule

@@ sv/actr_front.sv @@
// front end: takes requests, saturates and turns them into block jobs
// depends on actr_pkg
module actr_front import actr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COUNT_W-1:0] i_byte_count,
    output logic               o_job_valid,
    output t_job               o_job,
    input  logic               i_job_take
);
    t_job r_mem [FIFO_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [COUNT_W-1:0] n_sat;
    t_job n_job;
    logic push, pop;

    always_comb begin
        n_sat = (i_byte_count > COUNT_W'(MAX_REQUEST_BYTES)) ?
            COUNT_W'(MAX_REQUEST_BYTES) : i_byte_count;
        if (n_sat == '0) begin
            n_job.blocks = BLK_W'(1);
            n_job.last_bytes = '0;
        end else begin
            n_job.blocks = BLK_W'((n_sat + COUNT_W'(15)) >> 4);
            n_job.last_bytes = (n_sat[3:0] == 4'd0) ? VB_W'(16) : VB_W'(n_sat[3:0]);
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign pop = i_job_take && o_job_valid;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ sv/actr_back.sv @@
// back end: key schedule and one aes round per cycle (final round held while the output stalls), output register
// depends on actr_pkg
module actr_back import actr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_job_valid,
    input  t_job         i_job,
    output logic         o_job_take,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_block_low,
    output logic [63:0]  o_block_high,
    output logic [4:0]   o_valid_bytes,
    output logic         o_last_block
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]   r_state;
    logic [127:0] r_key0, r_key, r_st;
    logic [3:0]   r_rnd;
    logic [63:0]  r_ctr;
    logic [BLK_W-1:0] r_left;
    logic [VB_W-1:0]  r_lastb;
    logic [127:0] n_key, n_st;
    logic         r_ov;
    logic         is_last;
    logic         emit;

    assign is_last = (r_left == BLK_W'(1));
    assign n_key = next_key(r_key, r_rnd - 4'd1);
    assign n_st = aes_round(r_st, r_rnd == 4'd10) ^ key_to_state(n_key);
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign o_valid = r_ov;
    // final round result goes out when the output register is free or draining
    assign emit = (r_state == S_RUN) && (r_rnd == 4'd10) && (!r_ov || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_ctr <= '0;
            r_key0 <= '0;
        end else begin
            if (emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (i_cfg_we) begin
                r_key0 <= {i_cfg_data[7:0], i_cfg_data[15:8], i_cfg_data[23:16],
                           i_cfg_data[31:24], 96'h0};
                r_ctr <= '0;
            end
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_left <= i_job.blocks;
                    r_lastb <= i_job.last_bytes;
                    r_state <= S_OUT;
                    // start first block via the issue path below
                end
                S_RUN: begin
                    if (r_rnd != 4'd10) begin
                        r_st <= n_st;
                        r_key <= n_key;
                        r_rnd <= r_rnd + 4'd1;
                    end else if (emit) begin
                        o_block_low <= n_st[63:0];
                        o_block_high <= n_st[127:64];
                        o_valid_bytes <= is_last ? r_lastb : VB_W'(16);
                        o_last_block <= is_last;
                        r_left <= r_left - BLK_W'(1);
                        r_state <= is_last ? S_IDLE : S_OUT;
                    end
                    // otherwise hold the final round until the output frees
                end
                S_OUT: begin
                    // issue next block: bump counter, whiten with round key 0
                    r_ctr <= r_ctr + 64'd1;
                    r_st <= {64'h0, r_ctr + 64'd1} ^ key_to_state(r_key0);
                    r_key <= r_key0;
                    r_rnd <= 4'd1;
                    r_state <= S_RUN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/actr_checker.sv @@
// port-level checks for aes_ctr_random_bytes, bound to the top level
// depends on nothing but the top-level ports
module actr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_valid_bytes,
    input logic        o_last_block,
    input logic [63:0] o_block_low
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_block_low)) else $error("beat dropped");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_block |-> o_valid_bytes == 5'd16) else $error("short middle beat");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_valid_bytes <= 5'd16) else $error("valid bytes range");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind aes_ctr_random_bytes actr_checker u_chk (.*);

@@ tb/aes_ctr_random_bytes_tb.sv @@
// testbench for the aes-128 counter-mode random byte generator
// depends on actr_pkg and aes_ctr_random_bytes; self-checking against its own aes predictor
module aes_ctr_random_bytes_tb;
    import actr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  nbytes;
        logic        last;
    } t_block;

    typedef struct {
        logic [10:0] count;
        logic        has_exp;
        logic [4:0]  exp_bytes;
        logic        exp_last;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    logic [10:0]  i_byte_count = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [63:0]  o_block_low;
    logic [63:0]  o_block_high;
    logic [4:0]   o_valid_bytes;
    logic         o_last_block;

    aes_ctr_random_bytes dut (.*);

    always #5 i_clk = ~i_clk;

    localparam int IDLE_LIMIT = 20000;

    logic [7:0]  sb [256];
    logic [31:0] rk [44];
    logic [63:0] ctr_model;
    t_block      pending_blocks [$];
    t_row        rows [$];
    int          errors = 0;
    int          blocks_seen = 0;
    int          reqs_sent = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] subw(input logic [31:0] w);
        return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
    endfunction

    function automatic void load_seed(input logic [31:0] seed);
        logic [7:0]  rc [10];
        logic [31:0] t;
        rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
        rk[0] = {seed[7:0], seed[15:8], seed[23:16], seed[31:24]};
        rk[1] = '0; rk[2] = '0; rk[3] = '0;
        for (int i = 4; i < 44; i++) begin
            t = rk[i-1];
            if (i % 4 == 0) t = subw({t[23:0], t[31:24]}) ^ {rc[i/4-1], 24'h0};
            rk[i] = rk[i-4] ^ t;
        end
        ctr_model = '0;
    endfunction

    function automatic logic [127:0] cipher_counter(input logic [63:0] ctr);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = (i < 8) ? ctr[8*i +: 8] : 8'h00;
        for (int rnd = 0; rnd <= 10; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) t[4*c+r] = sb[s[4*((c+r)%4)+r]];
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    if (rnd == 10) begin
                        s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                    end else begin
                        s[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                        s[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                        s[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                        s[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4*c+r] ^= rk[4*rnd+c][24-8*r +: 8];
        end
        for (int i = 0; i < 16; i++) o[8*i +: 8] = s[i];
        return o;
    endfunction

    function automatic void predict_request(input logic [10:0] count);
        int n, nblk;
        t_block b;
        logic [127:0] c;
        n = (count > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : count;
        nblk = (n == 0) ? 1 : (n + 15) / 16;
        for (int k = 0; k < nblk; k++) begin
            ctr_model = ctr_model + 64'd1;
            c = cipher_counter(ctr_model);
            b.lo = c[63:0];
            b.hi = c[127:64];
            b.last = (k == nblk - 1);
            b.nbytes = b.last ? 5'(n - 16 * k) : 5'd16;
            pending_blocks.push_back(b);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch on block %0d: %s got %h expected %h", blocks_seen, what, got, want);
    endtask

    function automatic void add_row(input logic [10:0] count, input bit has_exp,
                                    input logic [4:0] eb, input logic el);
        t_row r;
        r.count = count; r.has_exp = has_exp; r.exp_bytes = eb; r.exp_last = el;
        rows.push_back(r);
    endfunction

    // output side: compare each accepted beat
    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0, 64'd0);
            end else begin
                want = pending_blocks.pop_front();
                if (o_block_low !== want.lo) report_mismatch("block_low", o_block_low, want.lo);
                if (o_block_high !== want.hi)
                    report_mismatch("block_high", o_block_high, want.hi);
                if (o_valid_bytes !== want.nbytes)
                    report_mismatch("valid_bytes", 64'(o_valid_bytes), 64'(want.nbytes));
                if (o_last_block !== want.last)
                    report_mismatch("last_block", 64'(o_last_block), 64'(want.last));
            end
            blocks_seen++;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no accepted request or beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d blocks outstanding", pending_blocks.size());
            $display("Verification failed");
            $finish;
        end
    end

    // valid stays high between back-to-back requests, drops only on idle cycles
    task automatic send_request(input logic [10:0] count);
        while (($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_byte_count <= count;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(count);
        reqs_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        i_cfg_we <= 1'b1;
        i_cfg_data <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        load_seed(seed);
        @(posedge i_clk);
    endtask

    function automatic logic [10:0] pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return 11'($urandom_range(48));
        if (sel < 80) return 11'($urandom_range(256));
        if (sel < 90) return 11'($urandom_range(2047));
        return 11'(16 * $urandom_range(1, 8));
    endfunction

    initial begin
        t_row r;
        sb = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        load_seed(32'h0);

        // directed table: byte count, check flag, then valid bytes and last flag of the final block
        add_row(11'd0,    1, 5'd0,  1'b1);   // zero-byte request still burns a counter value
        add_row(11'd1,    1, 5'd1,  1'b1);
        add_row(11'd15,   1, 5'd15, 1'b1);
        add_row(11'd16,   1, 5'd16, 1'b1);
        add_row(11'd17,   1, 5'd1,  1'b1);
        add_row(11'd32,   1, 5'd16, 1'b1);
        add_row(11'd1023, 1, 5'd15, 1'b1);
        add_row(11'd1024, 1, 5'd16, 1'b1);
        add_row(11'd1025, 1, 5'd16, 1'b1);   // oversized, saturates to the cap
        add_row(11'd2047, 1, 5'd16, 1'b1);
        add_row(11'd1365, 0, 5'd0,  1'b0);
        add_row(11'd682,  0, 5'd0,  1'b0);
        add_row(11'd3,    0, 5'd0,  1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            r = rows[i];
            // final block of this row is the last one the predictor queues
            send_request(r.count);
            if (r.has_exp && (pending_blocks[$].nbytes !== r.exp_bytes
                              || pending_blocks[$].last !== r.exp_last))
                report_mismatch("directed row", 64'(pending_blocks[$].nbytes),
                                64'(r.exp_bytes));
        end
        drain();

        // seed extremes and random seeds, each with a burst of requests
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_seed(32'hffff_ffff);
                1: write_seed(32'h0000_0000);
                default: write_seed($urandom());
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (ph == 3) begin
                // long hold-off at the output while requests keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    for (int k = 0; k < 8; k++) send_request(11'($urandom_range(40)));
                join
            end
            for (int k = 0; k < 30; k++) send_request(pick_count());
            drain();
        end

        $display("sent %0d requests over 7 seed settings, checked %0d blocks",
                 reqs_sent, blocks_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
